>>> rtl/hll_pkg.sv
`default_nettype none

package hll_pkg;

  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 3;

  // stage flag
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_APPLIED_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APPLIED_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_APPLIED_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DT        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 3'd7;

  localparam logic [31:0] UNITY_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic                operation;
    logic [IDX_W-1:0]    spin_index;
    logic signed [31:0]  spin_x;
    logic signed [31:0]  spin_y;
    logic signed [31:0]  spin_z;
    logic signed [31:0]  field_x;
    logic signed [31:0]  field_y;
    logic signed [31:0]  field_z;
    logic signed [31:0]  noise_x;
    logic signed [31:0]  noise_y;
    logic signed [31:0]  noise_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]    out_index;
    logic signed [31:0]  new_spin_x;
    logic signed [31:0]  new_spin_y;
    logic signed [31:0]  new_spin_z;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0][31:0] applied;
    logic [31:0]      moment;
    logic [31:0]      gyro;
    logic [30:0]      damping;
    logic [31:0]      dt;
  } cfg_t;

  // item context carried down the pipe; s[0] is x
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [2:0][31:0] s;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -64'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hll_stream_if.sv
`default_nettype none

interface hll_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/hll_rhs.sv
`default_nettype none

// total field, s x H, s x (s x H), rhs: ten stages
module hll_rhs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire hll_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  input  wire hll_pkg::in_t       in_data,
  output logic                    out_valid,
  output hll_pkg::ctx_t           out_ctx,
  output logic [2:0][31:0]        out_rhs
);

  localparam int NX [3] = '{1, 2, 0};
  localparam int NY [3] = '{2, 0, 1};

  logic [10:1]         vld;
  hll_pkg::ctx_t       ctx [1:10];
  logic signed [63:0]  am_p  [3];
  logic signed [32:0]  fn    [3];
  logic signed [31:0]  sum2  [3];
  logic signed [63:0]  hp3   [3];
  logic signed [31:0]  h4    [3];
  logic signed [63:0]  pa5   [3];
  logic signed [63:0]  pb5   [3];
  logic signed [31:0]  sxh6  [3];
  logic signed [63:0]  pa7   [3];
  logic signed [63:0]  pb7   [3];
  logic signed [31:0]  sxh7  [3];
  logic signed [31:0]  ssh8  [3];
  logic signed [31:0]  sxh8  [3];
  logic signed [63:0]  dp9   [3];
  logic signed [31:0]  sxh9  [3];
  logic signed [31:0]  rhs10 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[1].op  <= in_data.operation;
      ctx[1].idx <= in_data.spin_index;
      ctx[1].s   <= {in_data.spin_z, in_data.spin_y, in_data.spin_x};
      for (int k = 2; k <= 10; k++) ctx[k] <= ctx[k-1];

      am_p[0] <= $signed(cfg.applied[0]) * $signed({1'b0, cfg.moment});
      am_p[1] <= $signed(cfg.applied[1]) * $signed({1'b0, cfg.moment});
      am_p[2] <= $signed(cfg.applied[2]) * $signed({1'b0, cfg.moment});
      fn[0]   <= 33'(in_data.noise_x) + 33'(in_data.field_x);
      fn[1]   <= 33'(in_data.noise_y) + 33'(in_data.field_y);
      fn[2]   <= 33'(in_data.noise_z) + 33'(in_data.field_z);

      for (int j = 0; j < 3; j++) begin
        sum2[j] <= hll_pkg::sat32(64'(fn[j]) + 64'(hll_pkg::sat32(am_p[j] >>> 16)));
        hp3[j]  <= sum2[j] * $signed({1'b0, cfg.gyro});
        h4[j]   <= hll_pkg::sat32(hp3[j] >>> 16);
        pa5[j]  <= $signed(ctx[4].s[NX[j]]) * h4[NY[j]];
        pb5[j]  <= $signed(ctx[4].s[NY[j]]) * h4[NX[j]];
        sxh6[j] <= hll_pkg::sat32(((pa5[j] >>> 14) - (pb5[j] >>> 14)) >>> 16);
        pa7[j]  <= $signed(ctx[6].s[NX[j]]) * sxh6[NY[j]];
        pb7[j]  <= $signed(ctx[6].s[NY[j]]) * sxh6[NX[j]];
        sxh7[j] <= sxh6[j];
        ssh8[j] <= hll_pkg::sat32(((pa7[j] >>> 14) - (pb7[j] >>> 14)) >>> 16);
        sxh8[j] <= sxh7[j];
        dp9[j]  <= $signed({1'b0, cfg.damping}) * ssh8[j];
        sxh9[j] <= sxh8[j];
        rhs10[j] <= hll_pkg::sat32(-(64'(sxh9[j]) + (dp9[j] >>> 30)));
      end
    end
  end

  assign out_valid = vld[10];
  assign out_ctx   = ctx[10];
  assign out_rhs   = {rhs10[2], rhs10[1], rhs10[0]};

endmodule

`default_nettype wire

>>> rtl/hll_step.sv
`default_nettype none

// dt*rhs, predictor store, stepped spin: two stages
module hll_step #(
  parameter int SPIN_COUNT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic [31:0]                  dt,
  input  wire logic                         in_valid,
  input  wire hll_pkg::ctx_t                in_ctx,
  input  wire logic [2:0][31:0]             in_rhs,
  output logic                              out_valid,
  output logic [hll_pkg::IDX_W-1:0]         out_idx,
  output logic [2:0][31:0]                  out_v
);

  localparam int AW = (SPIN_COUNT > 1) ? $clog2(SPIN_COUNT) : 1;

  logic [95:0]        mem [SPIN_COUNT];
  logic               vld11, vld12;
  hll_pkg::ctx_t      ctx11;
  logic signed [63:0] prod11 [3];
  logic [95:0]        rdata11;
  logic [95:0]        fwd_data11;
  logic               fwd11;
  logic [hll_pkg::IDX_W-1:0] idx12;
  logic [2:0][31:0]   v12;

  logic               rng10, rng11, wr11;
  logic [AW-1:0]      addr10, addr11;
  logic [2:0][31:0]   half11, next_v;
  logic [95:0]        base11;

  assign rng10  = 32'(in_ctx.idx) < 32'(SPIN_COUNT);
  assign rng11  = 32'(ctx11.idx) < 32'(SPIN_COUNT);
  assign addr10 = AW'(in_ctx.idx);
  assign addr11 = AW'(ctx11.idx);
  assign wr11   = vld11 && (ctx11.op == hll_pkg::OP_PREDICT) && rng11;

  // same-index predictor one stage ahead: its write lands at this read edge
  assign base11 = !rng11 ? '0 : (fwd11 ? fwd_data11 : rdata11);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      half11[j] = hll_pkg::sat32(64'($signed(ctx11.s[j])) + (prod11[j] >>> 19));
      if (ctx11.op == hll_pkg::OP_CORRECT) begin
        next_v[j] = hll_pkg::sat32(64'($signed(base11[32*j +: 32])) + (prod11[j] >>> 19));
      end else begin
        next_v[j] = hll_pkg::sat32(64'($signed(ctx11.s[j])) + (prod11[j] >>> 18));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld11 <= 1'b0;
      vld12 <= 1'b0;
    end else if (en) begin
      vld11 <= in_valid;
      vld12 <= vld11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx11 <= in_ctx;
      for (int j = 0; j < 3; j++) begin
        prod11[j] <= $signed({1'b0, dt}) * $signed(in_rhs[j]);
      end
      rdata11    <= mem[addr10];
      fwd11      <= wr11 && (ctx11.idx == in_ctx.idx) && rng10;
      fwd_data11 <= half11;
      if (wr11) mem[addr11] <= half11;
      idx12 <= ctx11.idx;
      v12   <= next_v;
    end
  end

  assign out_valid = vld12;
  assign out_idx   = idx12;
  assign out_v     = v12;

endmodule

`default_nettype wire

>>> rtl/hll_norm.sv
`default_nettype none

// squares, 32-stage square root, 31-stage restoring divide per component
module hll_norm (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [hll_pkg::IDX_W-1:0]    in_idx,
  input  wire logic [2:0][31:0]             in_v,
  output logic                              out_valid,
  output hll_pkg::out_t                     out_data
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;
  localparam int DEPTH     = 2 + SQ_STEPS + DIV_STEPS + 1;

  logic [DEPTH-1:0]          vld;
  logic [63:0]               sq [3];
  logic [2:0][31:0]          v_sq;
  logic [hll_pkg::IDX_W-1:0] idx_sq;

  logic [63:0]               rem  [0:SQ_STEPS];
  logic [63:0]               root [0:SQ_STEPS];
  logic [2:0][31:0]          v_rt [0:SQ_STEPS];
  logic [hll_pkg::IDX_W-1:0] idx_rt [0:SQ_STEPS];

  logic [61:0]               drem [0:DIV_STEPS][3];
  logic [30:0]               dq   [0:DIV_STEPS][3];
  logic [2:0]                dneg [0:DIV_STEPS];
  logic [31:0]               dn   [0:DIV_STEPS];
  logic [hll_pkg::IDX_W-1:0] idx_dv [0:DIV_STEPS];

  logic [31:0] mag [3];
  logic [31:0] res [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq[j] <= 64'($signed(in_v[j]) * $signed(in_v[j]));
      end
      v_sq   <= in_v;
      idx_sq <= in_idx;
      rem[0]    <= sq[0] + sq[1] + sq[2];
      root[0]   <= '0;
      v_rt[0]   <= v_sq;
      idx_rt[0] <= idx_sq;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_STEPS - k));
    logic [63:0] trial;
    assign trial = root[k-1] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k-1] >= trial) begin
          rem[k]  <= rem[k-1] - trial;
          root[k] <= (root[k-1] >> 1) + BIT;
        end else begin
          rem[k]  <= rem[k-1];
          root[k] <= root[k-1] >> 1;
        end
        v_rt[k]   <= v_rt[k-1];
        idx_rt[k] <= idx_rt[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = v_rt[SQ_STEPS][j][31] ? (~v_rt[SQ_STEPS][j] + 32'd1) : v_rt[SQ_STEPS][j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        drem[0][j] <= {mag[j], 30'd0};
        dq[0][j]   <= '0;
        dneg[0][j] <= v_rt[SQ_STEPS][j][31];
      end
      dn[0]     <= root[SQ_STEPS][31:0];
      idx_dv[0] <= idx_rt[SQ_STEPS];
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - k;
    logic [61:0] dsh;
    assign dsh = {30'd0, dn[k-1]} << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          if (drem[k-1][j] >= dsh) begin
            drem[k][j]   <= drem[k-1][j] - dsh;
            dq[k][j]     <= dq[k-1][j] | (31'd1 << SH);
          end else begin
            drem[k][j]   <= drem[k-1][j];
            dq[k][j]     <= dq[k-1][j];
          end
        end
        dneg[k]   <= dneg[k-1];
        dn[k]     <= dn[k-1];
        idx_dv[k] <= idx_dv[k-1];
      end
    end
  end

  // zero norm gives a zero spin; quotient truncates toward zero
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dn[DIV_STEPS] == '0) res[j] = '0;
      else if (dneg[DIV_STEPS][j]) res[j] = -{1'b0, dq[DIV_STEPS][j]};
      else res[j] = {1'b0, dq[DIV_STEPS][j]};
    end
  end

  assign out_valid           = vld[DEPTH-1];
  assign out_data.out_index  = idx_dv[DIV_STEPS];
  assign out_data.new_spin_x = res[0];
  assign out_data.new_spin_y = res[1];
  assign out_data.new_spin_z = res[2];

endmodule

`default_nettype wire

>>> rtl/heun_llg_spin_update_core.sv
// Depth: 78 register stages, the first loaded at the edge that accepts
//   the input word.
// Throughput: one word per cycle; the whole pipe advances together and
//   halts only while the result word waits on the output side.
// Pipe: 10 stages field/rhs, 2 stages step and predictor store,
//   2 stages squares, 32 square-root stages, 1 + 31 divide stages.
// Reset (rst, synchronous): empties the pipe and loads register defaults;
//   the predictor store is not cleared and holds nothing valid until written.
`default_nettype none

module heun_llg_spin_update_core #(
  parameter int SPIN_COUNT = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst,
  hll_stream_if.sink   din,
  hll_stream_if.source dout,
  hll_stream_if.sink   cfg
);

  hll_pkg::cfg_t cfg_reg;

  // pipe advance: result slot empty or being taken
  logic en;
  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;
  assign cfg.ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.applied   <= '0;
      cfg_reg.moment    <= hll_pkg::UNITY_Q16;
      cfg_reg.gyro      <= hll_pkg::UNITY_Q16;
      cfg_reg.damping   <= '0;
      cfg_reg.dt        <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        hll_pkg::CFG_APPLIED_X: cfg_reg.applied[0] <= cfg.data.value;
        hll_pkg::CFG_APPLIED_Y: cfg_reg.applied[1] <= cfg.data.value;
        hll_pkg::CFG_APPLIED_Z: cfg_reg.applied[2] <= cfg.data.value;
        hll_pkg::CFG_MOMENT:    cfg_reg.moment     <= cfg.data.value;
        hll_pkg::CFG_GYRO:      cfg_reg.gyro       <= cfg.data.value;
        hll_pkg::CFG_DAMPING:   cfg_reg.damping    <= cfg.data.value[30:0];
        hll_pkg::CFG_DT:        cfg_reg.dt         <= cfg.data.value;
        default: ;
      endcase
    end
  end

  logic                      rhs_valid;
  hll_pkg::ctx_t             rhs_ctx;
  logic [2:0][31:0]          rhs_val;
  logic                      step_valid;
  logic [hll_pkg::IDX_W-1:0] step_idx;
  logic [2:0][31:0]          step_v;

  // field sum, gyro scaling, both cross products, damping, rhs
  hll_rhs u_rhs (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg_reg),
    .in_valid  (din.valid),
    .in_data   (din.data),
    .out_valid (rhs_valid),
    .out_ctx   (rhs_ctx),
    .out_rhs   (rhs_val)
  );

  // predictor writes s + dt/2*rhs; corrector reads it back with forwarding
  hll_step #(
    .SPIN_COUNT (SPIN_COUNT)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .dt        (cfg_reg.dt),
    .in_valid  (rhs_valid),
    .in_ctx    (rhs_ctx),
    .in_rhs    (rhs_val),
    .out_valid (step_valid),
    .out_idx   (step_idx),
    .out_v     (step_v)
  );

  // v / floor(sqrt(|v|^2)) in Q2.30
  hll_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (step_valid),
    .in_idx    (step_idx),
    .in_v      (step_v),
    .out_valid (dout.valid),
    .out_data  (dout.data)
  );

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) rst |=> !dout.valid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.ready) |-> !din.ready)
    else $error("input taken while result stalled");

  a_unknown_cfg_ignored: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.data.index == hll_pkg::CFG_UNUSED) |=> $stable(cfg_reg))
    else $error("unknown register index changed configuration");
`endif

endmodule

`default_nettype wire

>>> bench/spin_checker.sv
module spin_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             din_valid,
  input  logic             din_ready,
  input  hll_pkg::in_t     din_data,
  input  logic             dout_valid,
  input  logic             dout_ready,
  input  hll_pkg::out_t    dout_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  hll_pkg::cfg_wr_t cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  longint applied [3];
  longint moment_q, gyro_q, alpha_q, dt_q;
  logic signed [31:0] half_store [1024][3];
  hll_pkg::out_t spin_q[$];

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // (a*b - c*d) / 2^30, a and c Q2.30
  function automatic longint xterm(longint a, longint b, longint c, longint d);
    return clip32((((a * b) >>> 14) - ((c * d) >>> 14)) >>> 16);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned rem, root, b;
    rem = x;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic hll_pkg::out_t next_spin(hll_pkg::in_t it);
    longint s[3], h[3], sxh[3], ssh[3], rhs[3], v[3];
    longint fld[3], nse[3];
    longint am, sum, n, r, prod;
    longint unsigned sq;
    hll_pkg::out_t res;
    s[0] = longint'(it.spin_x); s[1] = longint'(it.spin_y); s[2] = longint'(it.spin_z);
    fld[0] = longint'(it.field_x); fld[1] = longint'(it.field_y);
    fld[2] = longint'(it.field_z);
    nse[0] = longint'(it.noise_x); nse[1] = longint'(it.noise_y);
    nse[2] = longint'(it.noise_z);
    for (int j = 0; j < 3; j++) begin
      am = clip32((applied[j] * moment_q) >>> 16);
      sum = clip32(nse[j] + fld[j] + am);
      h[j] = clip32((sum * gyro_q) >>> 16);
    end
    sxh[0] = xterm(s[1], h[2], s[2], h[1]);
    sxh[1] = xterm(s[2], h[0], s[0], h[2]);
    sxh[2] = xterm(s[0], h[1], s[1], h[0]);
    ssh[0] = xterm(s[1], sxh[2], s[2], sxh[1]);
    ssh[1] = xterm(s[2], sxh[0], s[0], sxh[2]);
    ssh[2] = xterm(s[0], sxh[1], s[1], sxh[0]);
    for (int j = 0; j < 3; j++)
      rhs[j] = clip32(-(sxh[j] + ((alpha_q * ssh[j]) >>> 30)));
    for (int j = 0; j < 3; j++) begin
      prod = dt_q * rhs[j];
      if (it.operation == hll_pkg::OP_PREDICT) begin
        half_store[it.spin_index][j] = 32'(clip32(s[j] + (prod >>> 19)));
        v[j] = clip32(s[j] + (prod >>> 18));
      end else begin
        v[j] = clip32(longint'(half_store[it.spin_index][j]) + (prod >>> 19));
      end
    end
    sq = 0;
    for (int j = 0; j < 3; j++) sq = sq + longint'(unsigned'(v[j] * v[j]));
    n = longint'(root64(sq));
    res.out_index = it.spin_index;
    for (int j = 0; j < 3; j++) begin
      r = (n > 0) ? (v[j] * 64'sd1073741824) / n : 0;
      v[j] = clip32(r);
    end
    res.new_spin_x = 32'(v[0]);
    res.new_spin_y = 32'(v[1]);
    res.new_spin_z = 32'(v[2]);
    return res;
  endfunction

  assign pending = spin_q.size();

  always @(posedge clk) begin
    hll_pkg::out_t want;
    if (rst) begin
      applied[0] <= 0; applied[1] <= 0; applied[2] <= 0;
      moment_q <= 65536; gyro_q <= 65536; alpha_q <= 0; dt_q <= 0;
      errors <= 0;
      spin_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          hll_pkg::CFG_APPLIED_X: applied[0] <= longint'($signed(cfg_data.value));
          hll_pkg::CFG_APPLIED_Y: applied[1] <= longint'($signed(cfg_data.value));
          hll_pkg::CFG_APPLIED_Z: applied[2] <= longint'($signed(cfg_data.value));
          hll_pkg::CFG_MOMENT:    moment_q <= longint'(cfg_data.value);
          hll_pkg::CFG_GYRO:      gyro_q <= longint'(cfg_data.value);
          hll_pkg::CFG_DAMPING:   alpha_q <= longint'(cfg_data.value[30:0]);
          hll_pkg::CFG_DT:        dt_q <= longint'(cfg_data.value);
          default: ;
        endcase
      end
      if (din_valid && din_ready) spin_q.push_back(next_spin(din_data));
      if (dout_valid && dout_ready) begin
        if (spin_q.size() == 0) begin
          if (errors < 10) $display("unexpected result word idx=%0d", dout_data.out_index);
          errors <= errors + 1;
        end else begin
          want = spin_q.pop_front();
          if (want !== dout_data) begin
            if (errors < 10)
              $display("mismatch exp idx=%0d %h %h %h got idx=%0d %h %h %h",
                       want.out_index, want.new_spin_x, want.new_spin_y, want.new_spin_z,
                       dout_data.out_index, dout_data.new_spin_x, dout_data.new_spin_y,
                       dout_data.new_spin_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2000000;  // cycles
  localparam int DRAIN = 100;      // beyond the pipe latency

  logic clk, rst;
  int   cycles, errors, pending;
  bit   written [1024];           // predictor entries that hold a value

  hll_stream_if #(.T(hll_pkg::in_t))     din ();
  hll_stream_if #(.T(hll_pkg::out_t))    dout ();
  hll_stream_if #(.T(hll_pkg::cfg_wr_t)) cfg ();

  heun_llg_spin_update_core u_top (
    .clk(clk), .rst(rst), .din(din.sink), .dout(dout.source), .cfg(cfg.sink)
  );

  spin_checker u_chk (
    .clk(clk), .rst(rst),
    .din_valid(din.valid), .din_ready(din.ready), .din_data(din.data),
    .dout_valid(dout.valid), .dout_ready(dout.ready), .dout_data(dout.data),
    .cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_data(cfg.data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side back-pressure: short stalls, a few long ones, some free-running stretches
  initial begin
    int n;
    dout.ready = 0;
    @(posedge clk);
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      dout.ready <= 1;
      repeat (n) @(posedge clk);
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      dout.ready <= 0;
      repeat (n) @(posedge clk);
    end
  end

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom) >>> $urandom_range(1, 4);
      2: return $signed($urandom) >>> $urandom_range(8, 24);
      3: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return ($urandom_range(0, 1)) ? 32'sd0 : -32'sd1;
    endcase
  endfunction

  // spin components below one half in Q2.30 most of the time
  function automatic logic signed [31:0] rnd_spin();
    if ($urandom_range(0, 4) == 0) return rnd_word();
    return $signed($urandom) >>> 2;
  endfunction

  function automatic hll_pkg::in_t mk_word(logic op, logic [hll_pkg::IDX_W-1:0] idx);
    hll_pkg::in_t it;
    it.operation = op;
    it.spin_index = idx;
    it.spin_x = rnd_spin(); it.spin_y = rnd_spin(); it.spin_z = rnd_spin();
    it.field_x = rnd_word(); it.field_y = rnd_word(); it.field_z = rnd_word();
    if ($urandom_range(0, 2) == 0) begin
      it.noise_x = 0; it.noise_y = 0; it.noise_z = 0;   // cold
    end else begin
      it.noise_x = rnd_word(); it.noise_y = rnd_word(); it.noise_z = rnd_word();
    end
    return it;
  endfunction

  // one input word; valid stays up when no gap follows
  task automatic send_word(hll_pkg::in_t it);
    int r, g;
    din.valid <= 1;
    din.data <= it;
    do @(negedge clk); while (!din.ready);
    @(posedge clk);
    if (it.operation == hll_pkg::OP_PREDICT) written[it.spin_index] = 1;
    r = $urandom_range(0, 19);
    g = (r < 12) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(20, 50);
    if (g > 0) begin
      din.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // sender holds off until the pipe has drained
  task automatic settle();
    din.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // writes the full register set back to back, then the unused index
  task automatic load_regs(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] mom, logic [31:0] gyr, logic [30:0] alpha,
                           logic [31:0] dt);
    hll_pkg::cfg_wr_t w [8];
    w[0] = '{hll_pkg::CFG_APPLIED_X, ax};
    w[1] = '{hll_pkg::CFG_APPLIED_Y, ay};
    w[2] = '{hll_pkg::CFG_APPLIED_Z, az};
    w[3] = '{hll_pkg::CFG_MOMENT, mom};
    w[4] = '{hll_pkg::CFG_GYRO, gyr};
    w[5] = '{hll_pkg::CFG_DAMPING, {1'b0, alpha}};
    w[6] = '{hll_pkg::CFG_DT, dt};
    w[7] = '{hll_pkg::CFG_UNUSED, $urandom};
    for (int k = 0; k < 8; k++) begin
      cfg.valid <= 1;
      cfg.data <= w[k];
      do @(negedge clk); while (!cfg.ready);
      @(posedge clk);
    end
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  // well-formed predict/correct batches, with some stray words mixed in
  task automatic random_phase(int n);
    int sent, b;
    logic [hll_pkg::IDX_W-1:0] ids [16];
    logic [hll_pkg::IDX_W-1:0] idx;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 6) == 0) begin
        idx = hll_pkg::IDX_W'($urandom);
        send_word(mk_word(written[idx] ? logic'($urandom_range(0, 1)) : hll_pkg::OP_PREDICT,
                          idx));
        sent++;
      end else begin
        b = $urandom_range(1, 16);
        for (int k = 0; k < b; k++) begin
          ids[k] = hll_pkg::IDX_W'($urandom);
          send_word(mk_word(hll_pkg::OP_PREDICT, ids[k]));
        end
        // a broken batch leaves some correctors out
        for (int k = 0; k < b; k++)
          if ($urandom_range(0, 9) != 0) send_word(mk_word(hll_pkg::OP_CORRECT, ids[k]));
        sent += 2 * b;
      end
      if (sent > n / 2 && sent < n / 2 + 20 && $urandom_range(0, 3) == 0) settle();
    end
  endtask

  initial begin
    hll_pkg::in_t it;
    cycles = 0;
    rst = 1;
    din.valid = 0;
    din.data = '0;
    cfg.valid = 0;
    cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed words at reset defaults (dt zero: predictors give the normalized input)
    it = '0;
    it.operation = hll_pkg::OP_PREDICT;
    it.spin_x = 32'sh4000_0000;
    send_word(it);
    it.spin_index = '1;
    it.spin_x = 32'sh7FFF_FFFF; it.spin_y = 32'sh7FFF_FFFF; it.spin_z = 32'sh7FFF_FFFF;
    send_word(it);
    it.spin_index = 10'd1;
    it.spin_x = 32'sh8000_0000; it.spin_y = 32'sh8000_0000; it.spin_z = 32'sh8000_0000;
    it.field_x = 32'sh7FFF_FFFF; it.noise_x = 32'sh7FFF_FFFF;
    it.field_y = 32'sh8000_0000; it.noise_y = 32'sh8000_0000;
    send_word(it);
    it = '0;                               // zero spin vector
    it.spin_index = 10'd2;
    send_word(it);
    it.operation = hll_pkg::OP_CORRECT;    // zero stored vector
    send_word(it);
    it.spin_index = 10'd0;
    send_word(it);
    it.spin_index = '1;
    send_word(it);
    it.spin_index = 10'd1;
    send_word(it);
    settle();

    // typical settings
    load_regs(32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000, hll_pkg::UNITY_Q16,
              hll_pkg::UNITY_Q16, 31'h0666_6666, 32'h0290_0000);
    for (int k = 0; k < 6; k++) send_word(mk_word(hll_pkg::OP_PREDICT, 10'(k)));
    for (int k = 0; k < 6; k++) send_word(mk_word(hll_pkg::OP_CORRECT, 10'(k)));
    random_phase(340);
    settle();

    // upper extremes, damping at the 31 bit maximum
    load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              31'h7FFF_FFFF, 32'hFFFF_FFFF);
    random_phase(300);
    settle();

    // lower extremes
    load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 31'h0, 32'h0);
    random_phase(300);
    settle();

    // damping one, dt large, mixed applied field
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, hll_pkg::UNITY_Q16,
              31'h4000_0000, 32'h8000_0000);
    random_phase(300);
    settle();

    for (int p = 0; p < 3; p++) begin
      load_regs($urandom, $urandom, $urandom, $urandom_range(0, 32'h0004_0000),
                $urandom_range(0, 32'h0004_0000), 31'($urandom_range(0, 32'h4000_0000)),
                $urandom);
      random_phase(280);
      settle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
